FILE: sv/assert_macros.svh
// assertion macros for the top rtl file of the command slot fifo
// no dependencies; SYNTH drops every check

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// check prop on every rising edge of clk outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check prop on every rising edge of clk, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: sv/csf_pkg.sv
// types and codes of the command slot fifo
// no dependencies

package csf_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] byte_in;
  } in_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] byte_out;
    logic       last;
  } out_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_BURST = 1'b1
  } state_t;

endpackage

FILE: sv/csf_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies

module csf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/command_slot_fifo_top.sv
// command slot fifo: ring of fixed-length command slots in one byte ram
// depends on csf_pkg, csf_ram and assert_macros.svh
//
//  channel | ports                        | beat
//  --------+------------------------------+------------------------------------
//  in      | in_valid in_ready in_data    | one action: write, read, clear, none
//  out     | out_valid out_ready out_data | one result: ok, byte_out, last
//
// every action except a successful read gives one beat
// a successful read streams CMD_BYTES beats, one per cycle, straight from the
// ram's registered read port; input is held off for the whole burst
// out_data sits in an output register, so the next action is taken while the
// previous result is being handed over
// a stalled out channel freezes the burst: the ram read data holds until taken
// synchronous active-low reset clears flags, pointers and fill count; slot
// bytes need no clearing since a slot is only read after all bytes are written

`include "assert_macros.svh"

module command_slot_fifo_top #(
  parameter int SLOTS     = 4,
  parameter int CMD_BYTES = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  csf_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output csf_pkg::out_t out_data
);

  localparam int DEPTH  = SLOTS * CMD_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int BYTE_W = (CMD_BYTES > 1) ? $clog2(CMD_BYTES) : 1;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
  localparam logic [BYTE_W-1:0] BYTE_LAST = BYTE_W'(CMD_BYTES - 1);
  localparam logic [ADDR_W-1:0] SLOT_SPAN = ADDR_W'(CMD_BYTES);

  // control state
  csf_pkg::state_t   st_r, st_nxt;
  logic [SLOTS-1:0]  ready_r, ready_nxt;   // slot holds a complete command
  logic [SLOT_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [SLOT_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [BYTE_W-1:0] fill_r, fill_nxt;     // fill of the slot under wr_ptr
  logic [BYTE_W-1:0] idx_r, idx_nxt;       // byte in flight during a burst

  // output register
  logic              out_valid_r, out_valid_nxt;
  csf_pkg::out_t     out_r, out_nxt;

  // ram port
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_rdata;

  logic              out_free, in_acc, res_load;
  logic              wr_busy, rd_hit, burst_end;
  csf_pkg::action_t  act;

  assign act       = csf_pkg::action_t'(in_data.action);
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (st_r == csf_pkg::ST_IDLE) && out_free;
  assign in_acc    = in_valid && in_ready;
  assign wr_busy   = ready_r[wr_ptr_r];
  assign rd_hit    = ready_r[rd_ptr_r];
  assign burst_end = (st_r == csf_pkg::ST_BURST) && out_free && (idx_r == BYTE_LAST);

  function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] p);
    wrap_inc = (p == SLOT_LAST) ? '0 : p + 1'b1;
  endfunction

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      csf_pkg::ST_IDLE: begin
        if (in_acc && act == csf_pkg::ACT_READ && rd_hit) begin
          st_nxt = csf_pkg::ST_BURST;
        end
      end
      csf_pkg::ST_BURST: begin
        if (burst_end) begin
          st_nxt = csf_pkg::ST_IDLE;
        end
      end
      default: st_nxt = csf_pkg::ST_IDLE;
    endcase
  end

  // ram accesses and result beat
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = ADDR_W'(wr_ptr_r) * SLOT_SPAN + ADDR_W'(fill_r);
    ram_raddr = ADDR_W'(rd_ptr_r) * SLOT_SPAN;
    res_load  = 1'b0;
    out_nxt   = '{ok: 1'b0, byte_out: 8'd0, last: 1'b1};
    case (st_r)
      csf_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (act)
            csf_pkg::ACT_WRITE: begin
              ram_we     = !wr_busy;
              res_load   = 1'b1;
              out_nxt.ok = !wr_busy;
            end
            csf_pkg::ACT_READ: begin
              // a hit starts the burst with byte zero; a miss gives one refusal
              ram_re   = rd_hit;
              res_load = !rd_hit;
            end
            csf_pkg::ACT_CLEAR: begin
              res_load   = 1'b1;
              out_nxt.ok = 1'b1;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      csf_pkg::ST_BURST: begin
        // read data for idx_r is on ram_rdata; fetch the next byte as it leaves
        ram_raddr = ADDR_W'(rd_ptr_r) * SLOT_SPAN + ADDR_W'(idx_r) + 1'b1;
        res_load  = out_free;
        ram_re    = out_free && (idx_r != BYTE_LAST);
        out_nxt   = '{ok: 1'b1, byte_out: ram_rdata, last: (idx_r == BYTE_LAST)};
      end
      default: begin
      end
    endcase
  end

  // flags, pointers and counters
  always_comb begin
    ready_nxt  = ready_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    idx_nxt    = idx_r;
    if (in_acc) begin
      case (act)
        csf_pkg::ACT_WRITE: begin
          if (!wr_busy) begin
            if (fill_r == BYTE_LAST) begin
              ready_nxt[wr_ptr_r] = 1'b1;
              wr_ptr_nxt          = wrap_inc(wr_ptr_r);
              fill_nxt            = '0;
            end else begin
              fill_nxt = fill_r + 1'b1;
            end
          end
        end
        csf_pkg::ACT_READ: begin
          idx_nxt = '0;
        end
        csf_pkg::ACT_CLEAR: begin
          ready_nxt  = '0;
          wr_ptr_nxt = '0;
          rd_ptr_nxt = '0;
          fill_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
    if (st_r == csf_pkg::ST_BURST && out_free) begin
      if (burst_end) begin
        ready_nxt[rd_ptr_r] = 1'b0;
        rd_ptr_nxt          = wrap_inc(rd_ptr_r);
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= csf_pkg::ST_IDLE;
      ready_r     <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      fill_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      ready_r     <= ready_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_r <= out_nxt;
    end
  end

  csf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.byte_in),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a burst holds off new actions
  `ASSERT_CLK(a_burst_blocks_in, clk, rst_n, (st_r == csf_pkg::ST_BURST) |-> !in_ready, "input taken during read burst")
  // a partly filled slot is never flagged ready
  `ASSERT_CLK(a_fill_not_ready, clk, rst_n, (fill_r != '0) |-> !ready_r[wr_ptr_r], "partly filled slot marked ready")
  // a read of a ready slot starts a burst in the next cycle
  `ASSERT_CLK(a_read_starts_burst, clk, rst_n, (in_acc && act == csf_pkg::ACT_READ && rd_hit) |=> (st_r == csf_pkg::ST_BURST), "ready read did not start burst")
  // the final burst beat returns to idle, flagged last
  `ASSERT_CLK(a_burst_end_idle, clk, rst_n, burst_end |=> (st_r == csf_pkg::ST_IDLE && out_valid_r && out_r.last), "burst did not end cleanly")

endmodule
